FILE: sv/tep_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tep_pkg: shared types and constants of the terminal escape parser
// Field widths, result kinds, marker codes, special bytes and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package tep_pkg;

   // sizing
   localparam int MAX_CSI_PARAMS = 16;
   localparam int OSC_LIMIT      = 256;
   localparam int RUN_LIMIT      = 16;
   localparam int PARAM_CAP      = 10000;

   localparam int BYTE_W  = 8;
   localparam int CP_W    = 21;
   localparam int KIND_W  = 3;
   localparam int MARK_W  = 3;
   localparam int INTER_W = 6;
   localparam int COUNT_W = 5;
   localparam int INDEX_W = 4;
   localparam int VALUE_W = 18;
   localparam int TOTAL_W = $clog2(MAX_CSI_PARAMS + 1);
   localparam int SLOT_W  = (MAX_CSI_PARAMS > 1) ? $clog2(MAX_CSI_PARAMS) : 1;
   localparam int OSC_W   = $clog2(OSC_LIMIT);
   localparam int CMP_W   = ((TOTAL_W > INDEX_W) ? TOTAL_W : INDEX_W) + 1;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_PRINT   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CONTROL = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ESC     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CSI     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_OSC     = 3'd4;
   localparam logic [KIND_W-1:0] KIND_OSC_END = 3'd5;

   // private marker codes
   localparam logic [MARK_W-1:0] MARK_NONE  = 3'd0;
   localparam logic [MARK_W-1:0] MARK_QUERY = 3'd1;
   localparam logic [MARK_W-1:0] MARK_GT    = 3'd2;
   localparam logic [MARK_W-1:0] MARK_LT    = 3'd3;
   localparam logic [MARK_W-1:0] MARK_BANG  = 3'd4;

   // special bytes
   localparam logic [BYTE_W-1:0] CHR_BEL   = 8'h07;
   localparam logic [BYTE_W-1:0] CHR_ESC   = 8'h1B;
   localparam logic [BYTE_W-1:0] CHR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHR_DEL   = 8'h7F;
   localparam logic [BYTE_W-1:0] CHR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHR_NINE  = 8'h39;
   localparam logic [BYTE_W-1:0] CHR_COLON = 8'h3A;
   localparam logic [BYTE_W-1:0] CHR_SEMI  = 8'h3B;
   localparam logic [BYTE_W-1:0] CHR_QUERY = 8'h3F;
   localparam logic [BYTE_W-1:0] CHR_GT    = 8'h3E;
   localparam logic [BYTE_W-1:0] CHR_LT    = 8'h3C;
   localparam logic [BYTE_W-1:0] CHR_BANG  = 8'h21;
   localparam logic [BYTE_W-1:0] CHR_INT_HI   = 8'h2F;
   localparam logic [BYTE_W-1:0] CHR_FINAL_LO = 8'h40;
   localparam logic [BYTE_W-1:0] CHR_FINAL_HI = 8'h7E;
   localparam logic [BYTE_W-1:0] CHR_CSI   = 8'h5B;
   localparam logic [BYTE_W-1:0] CHR_OSC   = 8'h5D;
   localparam logic [BYTE_W-1:0] CHR_DCS   = 8'h50;
   localparam logic [BYTE_W-1:0] CHR_APC   = 8'h5F;
   localparam logic [BYTE_W-1:0] CHR_PM    = 8'h5E;
   localparam logic [BYTE_W-1:0] CHR_SOS   = 8'h58;
   localparam logic [BYTE_W-1:0] CHR_G0    = 8'h28;
   localparam logic [BYTE_W-1:0] CHR_G1    = 8'h29;
   localparam logic [BYTE_W-1:0] CHR_G2    = 8'h2A;
   localparam logic [BYTE_W-1:0] CHR_G3    = 8'h2B;
   localparam logic [BYTE_W-1:0] CHR_HASH  = 8'h23;
   localparam logic [BYTE_W-1:0] CHR_PCT   = 8'h25;
   localparam logic [BYTE_W-1:0] CHR_RIS   = 8'h63;

   // byte classes and counters, datapath to controller
   typedef struct packed {
      logic is_c0;
      logic is_esc;
      logic is_bel;
      logic is_print;
      logic is_cont;
      logic is_lead;
      logic is_digit;
      logic is_sep;
      logic is_marker;
      logic is_interm;
      logic is_final;
      logic is_csi_intro;
      logic is_osc_intro;
      logic is_str_intro;
      logic is_charset;
      logic is_ris;
      logic utf_busy;
      logic utf_last;
      logic osc_room;
      logic run_last;
      logic out_free;
   } tep_status_type;

   // actions, controller to datapath
   typedef struct packed {
      logic              utf_start;
      logic              utf_shift;
      logic              utf_clear;
      logic              seq_clear;
      logic              param_digit;
      logic              param_sep;
      logic              marker_set;
      logic              interm_set;
      logic              final_latch;
      logic              osc_clear;
      logic              osc_count;
      logic              run_start;
      logic              run_read;
      logic              run_next;
      logic              out_load;
      logic [KIND_W-1:0] out_kind;
   } tep_cmd_type;

endpackage : tep_pkg
`default_nettype wire

FILE: sv/tep_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tep_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ----------------------------------------------------------------------------
module tep_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : tep_ram
`default_nettype wire

FILE: sv/tep_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tep_ctrl: parser controller
// Holds the parser state (ground, escape, escape intermediate, CSI, OSC,
// string) and the two states that walk a CSI dispatch run; turns the byte
// class into datapath actions and drives the input stall.
// ----------------------------------------------------------------------------
module tep_ctrl
   import tep_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire tep_status_type status,
   output tep_cmd_type         cmd
);

   localparam logic [2:0] ST_GND      = 3'd0;
   localparam logic [2:0] ST_ESC      = 3'd1;
   localparam logic [2:0] ST_ESCINT   = 3'd2;
   localparam logic [2:0] ST_CSI      = 3'd3;
   localparam logic [2:0] ST_OSC      = 3'd4;
   localparam logic [2:0] ST_STR_SKIP = 3'd5;
   localparam logic [2:0] ST_RUN_READ = 3'd6;
   localparam logic [2:0] ST_RUN_LOAD = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       in_phase;
   logic       accept;

   // input beats are taken outside a dispatch run when the output can take a result
   assign in_phase  = (state_ff != ST_RUN_READ) && (state_ff != ST_RUN_LOAD);
   assign req_stall = !(in_phase && status.out_free);
   assign accept    = req_valid && in_phase && status.out_free;

   // next state and actions
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_GND: begin
            if (accept) begin
               if (status.utf_busy && status.is_cont) begin
                  cmd.utf_shift = 1'b1;
                  if (status.utf_last) begin
                     cmd.out_load = 1'b1;
                     cmd.out_kind = KIND_PRINT;
                  end
               end else begin
                  // a broken sequence is dropped and the byte taken afresh
                  cmd.utf_clear = status.utf_busy;
                  if (status.is_c0) begin
                     if (status.is_esc) begin
                        state_in = ST_ESC;
                     end else begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = KIND_CONTROL;
                     end
                  end else if (status.is_print) begin
                     cmd.out_load = 1'b1;
                     cmd.out_kind = KIND_PRINT;
                  end else if (status.is_lead) begin
                     cmd.utf_start = 1'b1;
                  end
               end
            end
         end
         ST_ESC: begin
            if (accept) begin
               cmd.seq_clear = 1'b1;
               if (status.is_csi_intro) begin
                  state_in = ST_CSI;
               end else if (status.is_osc_intro) begin
                  cmd.osc_clear = 1'b1;
                  state_in      = ST_OSC;
               end else if (status.is_str_intro) begin
                  state_in = ST_STR_SKIP;
               end else if (status.is_charset) begin
                  cmd.interm_set = 1'b1;
                  state_in       = ST_ESCINT;
               end else begin
                  // full reset also drops the UTF-8 and OSC bookkeeping
                  cmd.utf_clear = status.is_ris;
                  cmd.osc_clear = status.is_ris;
                  cmd.out_load  = 1'b1;
                  cmd.out_kind  = KIND_ESC;
                  state_in      = ST_GND;
               end
            end
         end
         ST_ESCINT: begin
            if (accept) begin
               state_in = ST_GND;
            end
         end
         ST_CSI: begin
            if (accept) begin
               if (status.is_digit) begin
                  cmd.param_digit = 1'b1;
               end else if (status.is_sep) begin
                  cmd.param_sep = 1'b1;
               end else if (status.is_marker) begin
                  cmd.marker_set = 1'b1;
               end else if (status.is_interm) begin
                  cmd.interm_set = 1'b1;
               end else if (status.is_final) begin
                  cmd.final_latch = 1'b1;
                  cmd.run_start   = 1'b1;
                  state_in        = ST_RUN_READ;
               end else if (status.is_c0) begin
                  if (status.is_esc) begin
                     state_in = ST_ESC;
                  end else begin
                     cmd.out_load = 1'b1;
                     cmd.out_kind = KIND_CONTROL;
                  end
               end
            end
         end
         ST_OSC: begin
            if (accept) begin
               if (status.is_bel || status.is_esc) begin
                  cmd.out_load = 1'b1;
                  cmd.out_kind = KIND_OSC_END;
                  state_in     = status.is_bel ? ST_GND : ST_ESCINT;
               end else if (status.osc_room) begin
                  cmd.osc_count = 1'b1;
                  cmd.out_load  = 1'b1;
                  cmd.out_kind  = KIND_OSC;
               end
            end
         end
         ST_STR_SKIP: begin
            if (accept) begin
               if (status.is_esc) begin
                  state_in = ST_ESCINT;
               end else if (status.is_bel) begin
                  state_in = ST_GND;
               end
            end
         end
         ST_RUN_READ: begin
            cmd.run_read = 1'b1;
            state_in     = ST_RUN_LOAD;
         end
         ST_RUN_LOAD: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_CSI;
               if (status.run_last) begin
                  state_in = ST_GND;
               end else begin
                  cmd.run_next = 1'b1;
                  state_in     = ST_RUN_READ;
               end
            end
         end
         default: begin
            state_in = ST_GND;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_GND;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule : tep_ctrl
`default_nettype wire

FILE: sv/tep_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tep_datapath: parser datapath
// Byte classification, UTF-8 accumulator, CSI parameter collection with the
// parameter RAM, OSC length counter and the registered result stage.
// ----------------------------------------------------------------------------
module tep_datapath
   import tep_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [BYTE_W-1:0]         req_data_byte,
   input  wire logic                      rsp_stall,
   input  wire tep_cmd_type               cmd,
   output tep_status_type                 status,
   output logic                           rsp_valid,
   output logic        [KIND_W-1:0]       rsp_kind,
   output logic        [CP_W-1:0]         rsp_code_point,
   output logic        [BYTE_W-1:0]       rsp_final_byte,
   output logic        [MARK_W-1:0]       rsp_private_marker,
   output logic        [INTER_W-1:0]      rsp_intermediate_byte,
   output logic        [COUNT_W-1:0]      rsp_param_count,
   output logic        [INDEX_W-1:0]      rsp_param_index,
   output logic signed [VALUE_W-1:0]      rsp_param_value,
   output logic                           rsp_last_of_run
);

   localparam logic [VALUE_W-1:0] OMITTED = {VALUE_W{1'b1}};

   logic [BYTE_W-1:0] b;

   // parser bookkeeping
   logic [1:0]         utf_rem_ff, utf_rem_in;
   logic [CP_W-1:0]    utf_acc_ff, utf_acc_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               pending_ff, pending_in;
   logic [VALUE_W-1:0] cur_ff, cur_in;
   logic [MARK_W-1:0]  marker_ff, marker_in;
   logic [INTER_W-1:0] interm_ff, interm_in;
   logic [BYTE_W-1:0]  final_ff, final_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic [OSC_W-1:0]   osc_len_ff, osc_len_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [CP_W-1:0]    cp_ff, cp_in;
   logic [BYTE_W-1:0]  fin_ff, fin_in;
   logic [MARK_W-1:0]  mark_out_ff, mark_out_in;
   logic [INTER_W-1:0] inter_out_ff, inter_out_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               last_ff, last_in;

   logic               lead2, lead3, lead4;
   logic [MARK_W-1:0]  marker_code;
   logic [CP_W-1:0]    utf_word;
   logic [TOTAL_W-1:0] eff_total;
   logic [VALUE_W-1:0] eff_cur;
   logic               sep_room;
   logic [VALUE_W-1:0] digit_base;
   logic [VALUE_W-1:0] digit_value;
   logic [CMP_W-1:0]   idx_plus;
   logic [CMP_W-1:0]   emit_w;
   logic               run_is_cur;
   logic [VALUE_W-1:0] run_value;
   logic [VALUE_W-1:0] ram_rd_data;
   logic               ram_wr_en;

   assign b = req_data_byte;

   // byte classification
   assign lead2 = (b[7:5] == 3'b110);
   assign lead3 = (b[7:4] == 4'b1110);
   assign lead4 = (b[7:3] == 5'b11110);

   always_comb begin
      unique case (b)
         CHR_QUERY: marker_code = MARK_QUERY;
         CHR_GT:    marker_code = MARK_GT;
         CHR_LT:    marker_code = MARK_LT;
         CHR_BANG:  marker_code = MARK_BANG;
         default:   marker_code = MARK_NONE;
      endcase
   end

   assign status.is_c0        = (b < CHR_SPACE);
   assign status.is_esc       = (b == CHR_ESC);
   assign status.is_bel       = (b == CHR_BEL);
   assign status.is_print     = (b >= CHR_SPACE) && (b < CHR_DEL);
   assign status.is_cont      = (b[7:6] == 2'b10);
   assign status.is_lead      = lead2 || lead3 || lead4;
   assign status.is_digit     = (b >= CHR_ZERO) && (b <= CHR_NINE);
   assign status.is_sep       = (b == CHR_SEMI) || (b == CHR_COLON);
   assign status.is_marker    = (marker_code != MARK_NONE);
   assign status.is_interm    = (b >= CHR_SPACE) && (b <= CHR_INT_HI);
   assign status.is_final     = (b >= CHR_FINAL_LO) && (b <= CHR_FINAL_HI);
   assign status.is_csi_intro = (b == CHR_CSI);
   assign status.is_osc_intro = (b == CHR_OSC);
   assign status.is_str_intro = (b == CHR_DCS) || (b == CHR_APC) || (b == CHR_PM)
                                || (b == CHR_SOS);
   assign status.is_charset   = (b == CHR_G0) || (b == CHR_G1) || (b == CHR_G2)
                                || (b == CHR_G3) || (b == CHR_HASH) || (b == CHR_PCT);
   assign status.is_ris       = (b == CHR_RIS);
   assign status.utf_busy     = (utf_rem_ff != 2'd0);
   assign status.utf_last     = (utf_rem_ff == 2'd1);
   assign status.osc_room     = (osc_len_ff < OSC_W'(OSC_LIMIT - 1));
   assign status.out_free     = !rsp_valid_ff || !rsp_stall;

   // UTF-8 accumulator
   assign utf_word = {utf_acc_ff[CP_W-7:0], b[5:0]};

   always_comb begin
      utf_rem_in = utf_rem_ff;
      utf_acc_in = utf_acc_ff;
      if (cmd.utf_start) begin
         if (lead2) begin
            utf_rem_in = 2'd1;
            utf_acc_in = CP_W'(b[4:0]);
         end else if (lead3) begin
            utf_rem_in = 2'd2;
            utf_acc_in = CP_W'(b[3:0]);
         end else begin
            utf_rem_in = 2'd3;
            utf_acc_in = CP_W'(b[2:0]);
         end
      end else if (cmd.utf_shift) begin
         utf_rem_in = utf_rem_ff - 2'd1;
         utf_acc_in = utf_word;
      end else if (cmd.utf_clear) begin
         utf_rem_in = 2'd0;
      end
   end

   // CSI parameters: the open slot lives in cur_ff, closed slots in the RAM
   assign eff_total   = (total_ff == '0) ? TOTAL_W'(1) : total_ff;
   assign eff_cur     = (total_ff == '0) ? OMITTED : cur_ff;
   assign sep_room    = (eff_total < TOTAL_W'(MAX_CSI_PARAMS));
   assign digit_base  = ((total_ff == '0) || !pending_ff) ? '0 : cur_ff;
   assign digit_value = (digit_base < VALUE_W'(PARAM_CAP))
                        ? (digit_base << 3) + (digit_base << 1) + VALUE_W'(b[3:0])
                        : digit_base;
   assign ram_wr_en   = cmd.param_sep && sep_room;

   always_comb begin
      total_in   = total_ff;
      pending_in = pending_ff;
      cur_in     = cur_ff;
      marker_in  = marker_ff;
      interm_in  = interm_ff;
      final_in   = final_ff;
      idx_in     = idx_ff;
      if (cmd.seq_clear) begin
         total_in   = '0;
         pending_in = 1'b0;
         marker_in  = MARK_NONE;
         interm_in  = '0;
      end
      if (cmd.param_digit) begin
         total_in   = eff_total;
         pending_in = 1'b1;
         cur_in     = digit_value;
      end
      if (cmd.param_sep) begin
         pending_in = 1'b0;
         if (sep_room) begin
            total_in = eff_total + TOTAL_W'(1);
            cur_in   = OMITTED;
         end else begin
            total_in = eff_total;
            cur_in   = eff_cur;
         end
      end
      if (cmd.marker_set) begin
         marker_in = marker_code;
      end
      if (cmd.interm_set) begin
         interm_in = b[INTER_W-1:0];
      end
      if (cmd.final_latch) begin
         final_in = b;
      end
      if (cmd.run_start) begin
         idx_in = '0;
      end else if (cmd.run_next) begin
         idx_in = idx_ff + INDEX_W'(1);
      end
   end

   tep_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(MAX_CSI_PARAMS)
   ) u_param_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(SLOT_W'(eff_total - TOTAL_W'(1))),
      .wr_data(eff_cur),
      .rd_en  (cmd.run_read),
      .rd_addr(SLOT_W'(idx_ff)),
      .rd_data(ram_rd_data)
   );

   // dispatch run position
   assign idx_plus      = CMP_W'(idx_ff) + CMP_W'(1);
   assign emit_w        = (total_ff == '0) ? CMP_W'(1)
                        : ((total_ff > TOTAL_W'(RUN_LIMIT)) ? CMP_W'(RUN_LIMIT)
                                                            : CMP_W'(total_ff));
   assign status.run_last = (idx_plus == emit_w);
   assign run_is_cur    = (idx_plus == CMP_W'(total_ff));
   assign run_value     = (total_ff == '0) ? OMITTED
                        : (run_is_cur ? cur_ff : ram_rd_data);

   // OSC length
   always_comb begin
      osc_len_in = osc_len_ff;
      if (cmd.osc_clear) begin
         osc_len_in = '0;
      end else if (cmd.osc_count) begin
         osc_len_in = osc_len_ff + OSC_W'(1);
      end
   end

   // result stage: loaded only when empty or draining
   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);

   always_comb begin
      kind_in      = kind_ff;
      cp_in        = cp_ff;
      fin_in       = fin_ff;
      mark_out_in  = mark_out_ff;
      inter_out_in = inter_out_ff;
      count_in     = count_ff;
      index_in     = index_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      if (cmd.out_load) begin
         kind_in      = cmd.out_kind;
         cp_in        = '0;
         fin_in       = '0;
         mark_out_in  = MARK_NONE;
         inter_out_in = '0;
         count_in     = '0;
         index_in     = '0;
         value_in     = '0;
         last_in      = 1'b0;
         case (cmd.out_kind) inside
            KIND_PRINT: begin
               cp_in = (status.utf_busy && status.is_cont) ? utf_word : CP_W'(b);
            end
            KIND_CONTROL, KIND_OSC: begin
               cp_in = CP_W'(b);
            end
            KIND_ESC: begin
               fin_in = b;
            end
            KIND_CSI: begin
               fin_in       = final_ff;
               mark_out_in  = marker_ff;
               inter_out_in = interm_ff;
               count_in     = (TOTAL_W'(total_ff) > TOTAL_W'(31)) ? COUNT_W'(31)
                                                                 : COUNT_W'(total_ff);
               index_in     = idx_ff;
               value_in     = run_value;
               last_in      = status.run_last;
            end
            default: begin
               cp_in = '0;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         utf_rem_ff   <= 2'd0;
         utf_acc_ff   <= '0;
         total_ff     <= '0;
         pending_ff   <= 1'b0;
         marker_ff    <= MARK_NONE;
         interm_ff    <= '0;
         osc_len_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         utf_rem_ff   <= utf_rem_in;
         utf_acc_ff   <= utf_acc_in;
         total_ff     <= total_in;
         pending_ff   <= pending_in;
         marker_ff    <= marker_in;
         interm_ff    <= interm_in;
         osc_len_ff   <= osc_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      final_ff     <= final_in;
      idx_ff       <= idx_in;
      kind_ff      <= kind_in;
      cp_ff        <= cp_in;
      fin_ff       <= fin_in;
      mark_out_ff  <= mark_out_in;
      inter_out_ff <= inter_out_in;
      count_ff     <= count_in;
      index_ff     <= index_in;
      value_ff     <= value_in;
      last_ff      <= last_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_kind              = kind_ff;
   assign rsp_code_point        = cp_ff;
   assign rsp_final_byte        = fin_ff;
   assign rsp_private_marker    = mark_out_ff;
   assign rsp_intermediate_byte = inter_out_ff;
   assign rsp_param_count       = count_ff;
   assign rsp_param_index       = index_ff;
   assign rsp_param_value       = value_ff;
   assign rsp_last_of_run       = last_ff;

endmodule : tep_datapath
`default_nettype wire

FILE: sv/terminal_escape_parser_core.sv
`default_nettype none
// Print, control, ESC and OSC results are registered and shown in the cycle after the
// byte that causes them is accepted. One byte per cycle while the result register drains.
// A CSI final byte starts a run that, per result, reads the parameter RAM, then loads
// the result, for max(1, min(parameter count, RUN_LIMIT)) results; input stalls until the run ends.
// Reset (synchronous): parser to ground, counters and UTF-8 state cleared, result
// register empty; the parameter RAM is not cleared.
// ----------------------------------------------------------------------------
// terminal_escape_parser_core: byte-level front end of a character terminal
// Decodes UTF-8 prints, passes C0 controls, and emits ESC, CSI and OSC beats.
// ----------------------------------------------------------------------------
module terminal_escape_parser_core
   import tep_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [BYTE_W-1:0]         req_data_byte,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic        [KIND_W-1:0]       rsp_kind,
   output logic        [CP_W-1:0]         rsp_code_point,
   output logic        [BYTE_W-1:0]       rsp_final_byte,
   output logic        [MARK_W-1:0]       rsp_private_marker,
   output logic        [INTER_W-1:0]      rsp_intermediate_byte,
   output logic        [COUNT_W-1:0]      rsp_param_count,
   output logic        [INDEX_W-1:0]      rsp_param_index,
   output logic signed [VALUE_W-1:0]      rsp_param_value,
   output logic                           rsp_last_of_run
);

   tep_status_type status;
   tep_cmd_type    cmd;

   // parser state machine
   tep_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd)
   );

   // bookkeeping, parameter RAM and result register
   tep_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_data_byte        (req_data_byte),
      .rsp_stall            (rsp_stall),
      .cmd                  (cmd),
      .status               (status),
      .rsp_valid            (rsp_valid),
      .rsp_kind             (rsp_kind),
      .rsp_code_point       (rsp_code_point),
      .rsp_final_byte       (rsp_final_byte),
      .rsp_private_marker   (rsp_private_marker),
      .rsp_intermediate_byte(rsp_intermediate_byte),
      .rsp_param_count      (rsp_param_count),
      .rsp_param_index      (rsp_param_index),
      .rsp_param_value      (rsp_param_value),
      .rsp_last_of_run      (rsp_last_of_run)
   );

endmodule : terminal_escape_parser_core
`default_nettype wire

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for terminal_escape_parser_core
// Feeds host bytes through the request channel, starting with a short table of
// directed bytes and then random, mostly well-formed escape sequences. Each
// accepted byte runs through a behavioral parser in the bench, which queues
// the beats it should cause, or a directed row's typed beat in its place.
// Every beat that leaves the core is compared field by field with the oldest
// queued beat. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top
   import tep_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 410;
   localparam int IDLE_LIMIT   = 1000;
   localparam int DRAIN_CYCLES = 64;
   localparam logic [BYTE_W-1:0] CHR_BACKSLASH = 8'h5C;

   // parser states of the bench model
   typedef enum logic [2:0] {
      PS_GND, PS_ESC, PS_ESC_SEL, PS_CSI, PS_OSC, PS_STR_SKIP
   } parse_state_type;

   typedef struct packed {
      logic        [KIND_W-1:0]  kind;
      logic        [CP_W-1:0]    code_point;
      logic        [BYTE_W-1:0]  final_byte;
      logic        [MARK_W-1:0]  marker;
      logic        [INTER_W-1:0] interm;
      logic        [COUNT_W-1:0] count;
      logic        [INDEX_W-1:0] index;
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } beat_type;

   // directed row: a byte, plus a typed expectation where one is obvious
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              typed;
      logic [KIND_W-1:0] kind;
      logic [CP_W-1:0]   cp;
      logic [BYTE_W-1:0] fin;
   } row_type;

   localparam int NUM_ROWS = 26;
   localparam row_type STIM_TABLE [NUM_ROWS] = '{
      '{8'h41, 1'b1, KIND_PRINT,   21'h41, 8'h00},  // plain print
      '{8'h7E, 1'b1, KIND_PRINT,   21'h7E, 8'h00},  // top printable
      '{8'h00, 1'b1, KIND_CONTROL, 21'h00, 8'h00},  // NUL passes as control
      '{8'h1F, 1'b1, KIND_CONTROL, 21'h1F, 8'h00},  // top of C0
      '{8'h7F, 1'b0, KIND_PRINT,   21'h00, 8'h00},  // DEL dropped
      '{8'h80, 1'b0, KIND_PRINT,   21'h00, 8'h00},  // stray continuation
      '{8'hFF, 1'b0, KIND_PRINT,   21'h00, 8'h00},  // invalid lead
      '{8'hC3, 1'b0, KIND_PRINT,   21'h00, 8'h00},  // two-byte char
      '{8'hA9, 1'b0, KIND_PRINT,   21'h00, 8'h00},
      '{8'hE2, 1'b0, KIND_PRINT,   21'h00, 8'h00},  // lead broken by ASCII
      '{8'h41, 1'b0, KIND_PRINT,   21'h00, 8'h00},
      '{8'hF4, 1'b0, KIND_PRINT,   21'h00, 8'h00},  // largest code point
      '{8'h8F, 1'b0, KIND_PRINT,   21'h00, 8'h00},
      '{8'hBF, 1'b0, KIND_PRINT,   21'h00, 8'h00},
      '{8'hBF, 1'b0, KIND_PRINT,   21'h00, 8'h00},
      '{8'h1B, 1'b0, KIND_PRINT,   21'h00, 8'h00},  // ESC M
      '{8'h4D, 1'b1, KIND_ESC,     21'h00, 8'h4D},
      '{8'h1B, 1'b0, KIND_PRINT,   21'h00, 8'h00},  // CSI with no parameters
      '{8'h5B, 1'b0, KIND_PRINT,   21'h00, 8'h00},
      '{8'h6D, 1'b0, KIND_PRINT,   21'h00, 8'h00},
      '{8'h1B, 1'b0, KIND_PRINT,   21'h00, 8'h00},  // short OSC ended by BEL
      '{8'h5D, 1'b0, KIND_PRINT,   21'h00, 8'h00},
      '{8'h78, 1'b0, KIND_PRINT,   21'h00, 8'h00},
      '{8'h07, 1'b0, KIND_PRINT,   21'h00, 8'h00},
      '{8'h1B, 1'b0, KIND_PRINT,   21'h00, 8'h00},  // ESC c full reset
      '{8'h63, 1'b1, KIND_ESC,     21'h00, 8'h63}
   };

   // DUT ports
   logic                      clock;
   logic                      reset         = 1'b1;
   logic                      req_valid     = 1'b0;
   logic                      req_stall;
   logic        [BYTE_W-1:0]  req_data_byte = '0;
   logic                      rsp_valid;
   logic                      rsp_stall     = 1'b0;
   logic        [KIND_W-1:0]  rsp_kind;
   logic        [CP_W-1:0]    rsp_code_point;
   logic        [BYTE_W-1:0]  rsp_final_byte;
   logic        [MARK_W-1:0]  rsp_private_marker;
   logic        [INTER_W-1:0] rsp_intermediate_byte;
   logic        [COUNT_W-1:0] rsp_param_count;
   logic        [INDEX_W-1:0] rsp_param_index;
   logic signed [VALUE_W-1:0] rsp_param_value;
   logic                      rsp_last_of_run;

   // travels with the byte on the request side
   logic     row_typed = 1'b0;
   beat_type row_beat  = '0;

   beat_type          expected_beats[$];
   logic [BYTE_W-1:0] byte_q[$];
   int errors      = 0;
   int idle_cycles = 0;
   int stall_left  = 0;
   bit req_quiet   = 1'b0;
   bit rsp_quiet   = 1'b0;

   // bench copy of the parser state
   parse_state_type   st        = PS_GND;
   logic [1:0]        utf_todo  = '0;
   logic [CP_W-1:0]   utf_acc   = '0;
   int                p_store[MAX_CSI_PARAMS];
   int                p_total   = 0;
   bit                digit_pend = 1'b0;
   logic [MARK_W-1:0] marker    = MARK_NONE;
   logic [BYTE_W-1:0] interm    = '0;
   int                osc_len   = 0;

   terminal_escape_parser_core u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_data_byte         (req_data_byte),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_kind              (rsp_kind),
      .rsp_code_point        (rsp_code_point),
      .rsp_final_byte        (rsp_final_byte),
      .rsp_private_marker    (rsp_private_marker),
      .rsp_intermediate_byte (rsp_intermediate_byte),
      .rsp_param_count       (rsp_param_count),
      .rsp_param_index       (rsp_param_index),
      .rsp_param_value       (rsp_param_value),
      .rsp_last_of_run       (rsp_last_of_run)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
   endtask

   function automatic beat_type simple_beat(input logic [KIND_W-1:0] kind,
                                            input logic [CP_W-1:0] cp,
                                            input logic [BYTE_W-1:0] fin);
      beat_type r;
      r = '0;
      r.kind       = kind;
      r.code_point = cp;
      r.final_byte = fin;
      return r;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic logic [BYTE_W-1:0] pick_control();
      logic [BYTE_W-1:0] b;
      b = 8'($urandom_range(0, 31));
      return (b == CHR_ESC) ? CHR_BEL : b;
   endfunction

   task automatic push_beat(input bit record, input beat_type r);
      if (record) expected_beats.push_back(r);
   endtask

   // C0 in ground or CSI: ESC opens an escape, the rest go out as controls
   task automatic take_control(input logic [BYTE_W-1:0] b, input bit record);
      if (b == CHR_ESC) st = PS_ESC;
      else push_beat(record, simple_beat(KIND_CONTROL, CP_W'(b), 8'h00));
   endtask

   // advance the bench parser by one byte; queue its beats when record is set
   task automatic parse_byte(input logic [BYTE_W-1:0] b, input bit record);
      beat_type r;
      int       slot, n, emit, v;
      case (st)
         PS_GND: begin
            // pending UTF-8 run: take continuations, drop on anything else
            if (utf_todo != 0) begin
               if (b[7:6] == 2'b10) begin
                  utf_acc = {utf_acc[CP_W-7:0], b[5:0]};
                  utf_todo = utf_todo - 2'd1;
                  if (utf_todo == 0) push_beat(record, simple_beat(KIND_PRINT, utf_acc, 8'h00));
                  return;
               end
               utf_todo = '0;
            end
            if (b < CHR_SPACE) begin
               take_control(b, record);
            end else if (b < CHR_DEL) begin
               push_beat(record, simple_beat(KIND_PRINT, CP_W'(b), 8'h00));
            end else if (b[7:5] == 3'b110) begin
               utf_acc  = CP_W'(b[4:0]);
               utf_todo = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
               utf_acc  = CP_W'(b[3:0]);
               utf_todo = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
               utf_acc  = CP_W'(b[2:0]);
               utf_todo = 2'd3;
            end
         end
         PS_ESC: begin
            p_total    = 0;
            digit_pend = 1'b0;
            marker     = MARK_NONE;
            interm     = '0;
            if (b == CHR_CSI) begin
               st = PS_CSI;
            end else if (b == CHR_OSC) begin
               st      = PS_OSC;
               osc_len = 0;
            end else if (b == CHR_DCS || b == CHR_APC || b == CHR_PM || b == CHR_SOS) begin
               st = PS_STR_SKIP;
            end else if (b == CHR_G0 || b == CHR_G1 || b == CHR_G2 || b == CHR_G3 ||
                         b == CHR_HASH || b == CHR_PCT) begin
               interm = b;
               st     = PS_ESC_SEL;
            end else begin
               if (b == CHR_RIS) begin
                  utf_todo = '0;
                  osc_len  = 0;
               end
               push_beat(record, simple_beat(KIND_ESC, '0, b));
               st = PS_GND;
            end
         end
         PS_ESC_SEL: st = PS_GND;
         PS_CSI: begin
            if (b >= CHR_ZERO && b <= CHR_NINE) begin
               if (p_total == 0) begin
                  p_total    = 1;
                  p_store[0] = 0;
               end
               slot = p_total - 1;
               if (!digit_pend) begin
                  p_store[slot] = 0;
                  digit_pend    = 1'b1;
               end
               // value saturates once it reaches the cap
               if (p_store[slot] < PARAM_CAP)
                  p_store[slot] = p_store[slot] * 10 + int'(b - CHR_ZERO);
            end else if (b == CHR_SEMI || b == CHR_COLON) begin
               if (p_total == 0) begin
                  p_total    = 1;
                  p_store[0] = -1;
               end
               if (p_total < MAX_CSI_PARAMS) begin
                  p_store[p_total] = -1;
                  p_total++;
               end
               digit_pend = 1'b0;
            end else if (b == CHR_QUERY) begin
               marker = MARK_QUERY;
            end else if (b == CHR_GT) begin
               marker = MARK_GT;
            end else if (b == CHR_LT) begin
               marker = MARK_LT;
            end else if (b == CHR_BANG) begin
               marker = MARK_BANG;
            end else if (b >= CHR_SPACE && b <= CHR_INT_HI) begin
               interm = b;
            end else if (b >= CHR_FINAL_LO && b <= CHR_FINAL_HI) begin
               // dispatch: one beat per parameter, at least one and at most RUN_LIMIT
               n    = p_total;
               emit = (n == 0) ? 1 : ((n > RUN_LIMIT) ? RUN_LIMIT : n);
               for (int i = 0; i < emit; i++) begin
                  v            = (n == 0 || i >= MAX_CSI_PARAMS) ? -1 : p_store[i];
                  r            = simple_beat(KIND_CSI, '0, b);
                  r.marker     = marker;
                  r.interm     = interm[INTER_W-1:0];
                  r.count      = COUNT_W'((n > 31) ? 31 : n);
                  r.index      = INDEX_W'(i);
                  r.value      = VALUE_W'(v);
                  r.last       = (i + 1 == emit);
                  push_beat(record, r);
               end
               st = PS_GND;
            end else if (b < CHR_SPACE) begin
               take_control(b, record);
            end
         end
         PS_OSC: begin
            if (b == CHR_BEL || b == CHR_ESC) begin
               push_beat(record, simple_beat(KIND_OSC_END, '0, 8'h00));
               st = (b == CHR_BEL) ? PS_GND : PS_ESC_SEL;
            end else if (osc_len < OSC_LIMIT - 1) begin
               osc_len++;
               push_beat(record, simple_beat(KIND_OSC, CP_W'(b), 8'h00));
            end
         end
         PS_STR_SKIP: begin
            if (b == CHR_ESC) st = PS_ESC_SEL;
            else if (b == CHR_BEL) st = PS_GND;
         end
         default: st = PS_GND;
      endcase
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_error($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   // one random sequence of host bytes, mostly well-formed
   task automatic queue_sequence();
      int                len, nparm;
      logic [BYTE_W-1:0] b;
      case ($urandom_range(0, 15)) inside
         0, 1, 2: begin
            len = $urandom_range(1, 6);
            repeat (len) byte_q.push_back(8'($urandom_range(32, 126)));
         end
         3, 4: begin
            len = $urandom_range(1, 3);
            case (len)
               1:       byte_q.push_back(8'hC0 | 8'($urandom_range(0, 31)));
               2:       byte_q.push_back(8'hE0 | 8'($urandom_range(0, 15)));
               default: byte_q.push_back(8'hF0 | 8'($urandom_range(0, 7)));
            endcase
            repeat (len) byte_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
         end
         5: byte_q.push_back(pick_control());
         6, 7, 8: begin
            // CSI with random marker, parameters, noise and final
            byte_q.push_back(CHR_ESC);
            byte_q.push_back(CHR_CSI);
            if ($urandom_range(0, 2) == 0) begin
               case ($urandom_range(0, 3))
                  0:       byte_q.push_back(CHR_QUERY);
                  1:       byte_q.push_back(CHR_GT);
                  2:       byte_q.push_back(CHR_LT);
                  default: byte_q.push_back(CHR_BANG);
               endcase
            end
            nparm = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 4);
            for (int k = 0; k < nparm; k++) begin
               if (k > 0)
                  byte_q.push_back(($urandom_range(0, 3) == 0) ? CHR_COLON : CHR_SEMI);
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 3);
               repeat (len) byte_q.push_back(CHR_ZERO + 8'($urandom_range(0, 9)));
               if ($urandom_range(0, 19) == 0) byte_q.push_back(8'($urandom_range(127, 255)));
               if ($urandom_range(0, 19) == 0) byte_q.push_back(pick_control());
            end
            if ($urandom_range(0, 3) == 0)
               byte_q.push_back(8'($urandom_range(CHR_SPACE, CHR_INT_HI)));
            if ($urandom_range(0, 11) == 0) byte_q.push_back(CHR_ESC);
            else byte_q.push_back(8'($urandom_range(CHR_FINAL_LO, CHR_FINAL_HI)));
         end
         9, 10: begin
            // OSC, now and then long enough to overflow
            byte_q.push_back(CHR_ESC);
            byte_q.push_back(CHR_OSC);
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(250, 260) : $urandom_range(0, 8);
            repeat (len) begin
               b = 8'($urandom_range(8, 255));
               byte_q.push_back((b == CHR_ESC) ? CHR_SPACE : b);
            end
            if ($urandom_range(0, 1) == 0) begin
               byte_q.push_back(CHR_BEL);
            end else begin
               byte_q.push_back(CHR_ESC);
               byte_q.push_back(($urandom_range(0, 1) == 0) ? CHR_BACKSLASH
                                                            : 8'($urandom_range(0, 255)));
            end
         end
         11: begin
            byte_q.push_back(CHR_ESC);
            byte_q.push_back(($urandom_range(0, 4) == 0) ? CHR_RIS : 8'($urandom_range(48, 126)));
         end
         12: begin
            byte_q.push_back(CHR_ESC);
            case ($urandom_range(0, 5))
               0:       byte_q.push_back(CHR_G0);
               1:       byte_q.push_back(CHR_G1);
               2:       byte_q.push_back(CHR_G2);
               3:       byte_q.push_back(CHR_G3);
               4:       byte_q.push_back(CHR_HASH);
               default: byte_q.push_back(CHR_PCT);
            endcase
            byte_q.push_back(8'($urandom_range(0, 255)));
         end
         13: begin
            // swallowed string
            byte_q.push_back(CHR_ESC);
            case ($urandom_range(0, 3))
               0:       byte_q.push_back(CHR_DCS);
               1:       byte_q.push_back(CHR_APC);
               2:       byte_q.push_back(CHR_PM);
               default: byte_q.push_back(CHR_SOS);
            endcase
            len = $urandom_range(0, 6);
            repeat (len) byte_q.push_back(8'($urandom_range(32, 255)));
            if ($urandom_range(0, 1) == 0) begin
               byte_q.push_back(CHR_BEL);
            end else begin
               byte_q.push_back(CHR_ESC);
               byte_q.push_back(CHR_BACKSLASH);
            end
         end
         14: byte_q.push_back(8'($urandom_range(0, 255)));
         default: begin
            // lead byte cut short by a non-continuation
            byte_q.push_back(8'($urandom_range(192, 247)));
            byte_q.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 127))
                                                         : 8'($urandom_range(192, 247)));
         end
      endcase
   endtask

   // present one byte and hold it until accepted; valid stays up across back-to-back beats
   task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed, input beat_type want);
      int gap;
      if ($urandom_range(0, 99) == 0) req_quiet = !req_quiet;
      gap = req_quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      row_typed     <= typed;
      row_beat      <= want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // result side stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else begin
         if ($urandom_range(0, 299) == 0) rsp_quiet = !rsp_quiet;
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (!rsp_quiet && $urandom_range(0, 2) == 0) stall_left = pick_gap();
         end
      end
   end

   // check result beats, then predict from the accepted byte
   always @(posedge clock) begin : monitor
      beat_type got, want;
      bit       moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            got = '{rsp_kind, rsp_code_point, rsp_final_byte, rsp_private_marker,
                    rsp_intermediate_byte, rsp_param_count, rsp_param_index,
                    rsp_param_value, rsp_last_of_run};
            if (expected_beats.size() == 0) begin
               report_error($sformatf("unexpected beat, kind %0h", got.kind));
            end else begin
               want = expected_beats.pop_front();
               compare_field("kind",              32'(got.kind),       32'(want.kind));
               compare_field("code_point",        32'(got.code_point), 32'(want.code_point));
               compare_field("final_byte",        32'(got.final_byte), 32'(want.final_byte));
               compare_field("private_marker",    32'(got.marker),     32'(want.marker));
               compare_field("intermediate_byte", 32'(got.interm),     32'(want.interm));
               compare_field("param_count",       32'(got.count),      32'(want.count));
               compare_field("param_index",       32'(got.index),      32'(want.index));
               compare_field("param_value",       32'(got.value),      32'(want.value));
               compare_field("last_of_run",       32'(got.last),       32'(want.last));
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            parse_byte(req_data_byte, !row_typed);
            if (row_typed) expected_beats.push_back(row_beat);
         end
         idle_cycles <= moved ? 0 : idle_cycles + 1;
      end
   end

   // watchdog on cycles without any accepted beat
   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      int sent;
      foreach (p_store[i]) p_store[i] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < NUM_ROWS; i++)
         send_byte(STIM_TABLE[i].data, STIM_TABLE[i].typed,
                   simple_beat(STIM_TABLE[i].kind, STIM_TABLE[i].cp, STIM_TABLE[i].fin));

      // random sequences, finishing the one under way
      sent = 0;
      while (sent < RANDOM_ITEMS || byte_q.size() != 0) begin
         if (byte_q.size() == 0) queue_sequence();
         send_byte(byte_q.pop_front(), 1'b0, '0);
         sent++;
      end
      req_valid <= 1'b0;

      // drain, then give a late extra beat time to show up
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule : tb_top

FILE: terminal_escape_parser_core.f
sv/tep_pkg.sv
sv/tep_ram.sv
sv/tep_ctrl.sv
sv/tep_datapath.sv
sv/terminal_escape_parser_core.sv
test/tb_top.sv
